>>> rtl/epoch_seconds_to_calendar_assert.svh
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_assert.svh
// Assertion macros for the calendar converter; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT_IMP(lbl, ante, cons, msg)
`define ESC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg
// Types, constants and span tables for the seconds-to-calendar converter.
// ---------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SEC_W  = 32;
  localparam int unsigned YEAR_W = 12;

  localparam logic [YEAR_W-1:0] BASE_YEAR_RST = 12'd1970;
  localparam logic [YEAR_W-1:0] YEAR_MAX      = 12'd4095;
  localparam logic [YEAR_W-1:0] CYCLE_LAST    = 12'd399;

  localparam logic [SEC_W-1:0] SECS_DAY    = 32'd86400;
  localparam logic [SEC_W-1:0] SECS_HOUR   = 32'd3600;
  localparam logic [SEC_W-1:0] SECS_MIN    = 32'd60;
  localparam logic [SEC_W-1:0] YEARS_CYCLE = 32'd400;
  localparam logic [SEC_W-1:0] SECS_YEAR   = 32'd31536000;
  localparam logic [SEC_W-1:0] SECS_LYEAR  = 32'd31622400;

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_OUT
  } esc_state_t;

  typedef struct packed {
    esc_state_t state;
    logic       load;
    logic       step;
    logic       busy;
    logic       done;
  } esc_ctrl_t;

  typedef struct packed {
    logic geq;
    logic month_last;
  } esc_stat_t;

  // leap rule from the year reduced modulo 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] ymod);
    return (ymod[1:0] == 2'b00) &&
           (ymod != 12'd100) && (ymod != 12'd200) && (ymod != 12'd300);
  endfunction

  function automatic logic [SEC_W-1:0] month_span(input logic [3:0] m, input logic leap);
    logic [SEC_W-1:0] s;
    case (m)
      MONTH_FEB:                 s = leap ? 32'd2505600 : 32'd2419200;
      4'd3, 4'd5, 4'd8, 4'd10:   s = 32'd2592000;
      default:                   s = 32'd2678400;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/epoch_seconds_to_calendar.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a seconds count since January 1 of a base year to a Gregorian
// date and time of day by repeated subtraction.
// ---------------------------------------------------------------------------
// channel   ports                                       handshake
// input     in_seconds_count                            start & !busy
// result    out_year/month/day/hour/minute/second       out_valid, one cycle
// config    cfg_wdata                                   cfg_we
//
// A transaction steps through the phases in order (modulo 400, years,
// months, days, hours, minutes) and then shows the result; each phase
// runs past its last step. The shared subtractor sets the pace.
// Synchronous reset sets base_year to 1970 and returns to idle.
// busy is high from acceptance until the cycle after out_valid; the
// receiver cannot stall, results are shown for exactly one cycle.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [esc_pkg::YEAR_W-1:0] cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [esc_pkg::SEC_W-1:0]  in_seconds_count,
  output logic                       out_valid,
  output logic [esc_pkg::YEAR_W-1:0] out_year,
  output logic [3:0]                 out_month,
  output logic [4:0]                 out_day,
  output logic [4:0]                 out_hour,
  output logic [5:0]                 out_minute,
  output logic [5:0]                 out_second
);
  import esc_pkg::*;

  esc_ctrl_t ctrl;
  esc_stat_t stat;

  logic [YEAR_W-1:0] base_r;
  logic [SEC_W-1:0]  rest_r;
  logic [YEAR_W-1:0] year_r;
  logic [YEAR_W-1:0] ymod_r;   // year modulo 400 once the first phase ends
  logic [3:0]        month_r;
  logic [4:0]        day_r;
  logic [4:0]        hour_r;
  logic [5:0]        min_r;

  logic [SEC_W-1:0] op_a, op_b, diff;
  logic             geq, leap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_YEAR_RST;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  assign leap = is_leap(ymod_r);

  always_comb begin
    op_a = rest_r;
    op_b = SECS_MIN;
    case (ctrl.state)
      S_MOD: begin
        op_a = {{(SEC_W-YEAR_W){1'b0}}, ymod_r};
        op_b = YEARS_CYCLE;
      end
      S_YEAR:  op_b = leap ? SECS_LYEAR : SECS_YEAR;
      S_MONTH: op_b = month_span(month_r, leap);
      S_DAY:   op_b = SECS_DAY;
      S_HOUR:  op_b = SECS_HOUR;
      default: op_b = SECS_MIN;
    endcase
  end

  esc_sub u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .geq  (geq)
  );

  assign stat.geq        = geq;
  assign stat.month_last = (month_r == MONTH_LAST);

  esc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rest_r  <= in_seconds_count;
      year_r  <= base_r;
      ymod_r  <= base_r;
      month_r <= '0;
      day_r   <= 5'd1;
      hour_r  <= '0;
      min_r   <= '0;
    end else if (ctrl.step) begin
      case (ctrl.state)
        S_MOD: ymod_r <= diff[YEAR_W-1:0];
        S_YEAR: begin
          rest_r <= diff;
          year_r <= year_r + 12'd1;
          // the 12-bit year wraps to zero, which restarts the 400-year cycle
          if (year_r == YEAR_MAX || ymod_r == CYCLE_LAST) begin
            ymod_r <= '0;
          end else begin
            ymod_r <= ymod_r + 12'd1;
          end
        end
        S_MONTH: begin
          rest_r  <= diff;
          month_r <= month_r + 4'd1;
        end
        S_DAY: begin
          rest_r <= diff;
          day_r  <= day_r + 5'd1;
        end
        S_HOUR: begin
          rest_r <= diff;
          hour_r <= hour_r + 5'd1;
        end
        S_MIN: begin
          rest_r <= diff;
          min_r  <= min_r + 6'd1;
        end
        default: rest_r <= rest_r;
      endcase
    end
  end

  assign busy       = ctrl.busy;
  assign out_valid  = ctrl.done;
  assign out_year   = year_r;
  assign out_month  = month_r + 4'd1;
  assign out_day    = day_r;
  assign out_hour   = hour_r;
  assign out_minute = min_r;
  assign out_second = rest_r[5:0];

  `ESC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `ESC_ASSERT_NXT(a_done_idle, out_valid, !busy && !out_valid, "busy held after result")
  `ESC_ASSERT_IMP(a_month_range, out_valid, out_month >= 4'd1 && out_month <= 4'd12,
    "month out of range")
  `ESC_ASSERT_IMP(a_tod_range, out_valid, out_hour < 5'd24 && out_minute < 6'd60 &&
    rest_r < SECS_MIN && out_day >= 5'd1, "time of day out of range")

endmodule

>>> rtl/esc_sub.sv
// ---------------------------------------------------------------------------
// esc_sub
// Shared 32-bit subtract and compare unit.
// ---------------------------------------------------------------------------
module esc_sub (
  input  logic [esc_pkg::SEC_W-1:0] a,
  input  logic [esc_pkg::SEC_W-1:0] b,
  output logic [esc_pkg::SEC_W-1:0] diff,
  output logic                      geq
);
  import esc_pkg::*;

  logic [SEC_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[SEC_W-1:0];
  assign geq  = ~full[SEC_W];

endmodule

>>> rtl/esc_seq.sv
// ---------------------------------------------------------------------------
// esc_seq
// Sequencer: walks the phases, one subtract step per cycle.
// ---------------------------------------------------------------------------
module esc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  esc_pkg::esc_stat_t stat,
  output esc_pkg::esc_ctrl_t ctrl
);
  import esc_pkg::*;

  esc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MOD;
      S_MOD:   if (!stat.geq) state_nxt = S_YEAR;
      S_YEAR:  if (!stat.geq) state_nxt = S_MONTH;
      S_MONTH: if (!stat.geq || stat.month_last) state_nxt = S_DAY;
      S_DAY:   if (!stat.geq) state_nxt = S_HOUR;
      S_HOUR:  if (!stat.geq) state_nxt = S_MIN;
      S_MIN:   if (!stat.geq) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.state = state_r;
    ctrl.load  = 1'b0;
    ctrl.step  = 1'b0;
    ctrl.busy  = 1'b1;
    ctrl.done  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.busy = 1'b0;
        ctrl.load = start;
      end
      S_MOD, S_YEAR, S_DAY, S_HOUR, S_MIN: ctrl.step = stat.geq;
      S_MONTH: ctrl.step = stat.geq && !stat.month_last;
      S_OUT:   ctrl.done = 1'b1;
      default: ctrl.busy = 1'b1;
    endcase
  end

endmodule

>>> sim/epoch_seconds_to_calendar_test.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Self-checking bench for the seconds-to-calendar converter. A driver feeds
// seconds counts from a queue and predicts each date at acceptance; a monitor
// checks every strobed result against the oldest prediction. The base year
// is rewritten between phases (reset value, range ends, year-counter wrap,
// out-of-range bases, random bases).
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PHASE_ITEMS  = 156;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } calendar_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [YEAR_W-1:0] cfg_wdata = '0;
  logic              start = 1'b0;
  logic [SEC_W-1:0]  in_seconds_count = '0;
  logic              busy;
  logic              out_valid;
  logic [YEAR_W-1:0] out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;

  logic [SEC_W-1:0]  pending_counts[$];
  calendar_t         expected_dates[$];
  logic [YEAR_W-1:0] model_base;
  calendar_t         want;
  bit                steady = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       sent_count = 0;
  int unsigned       checked_count = 0;
  int unsigned       wrapped_count = 0;

  epoch_seconds_to_calendar uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_seconds_count (in_seconds_count),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---- calendar arithmetic on the 12-bit wrapping year counter ----
  function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
    int unsigned v;
    v = y;
    return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(input logic [YEAR_W-1:0] y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned m,
                                               input logic [YEAR_W-1:0] y);
    int unsigned d;
    case (m)
      1:             d = is_leap_year(y) ? 29 : 28;
      3, 5, 8, 10:   d = 30;
      default:       d = 31;
    endcase
    return d;
  endfunction

  function automatic calendar_t to_calendar(input logic [SEC_W-1:0] secs,
                                            input logic [YEAR_W-1:0] base);
    int unsigned       rest;
    int unsigned       mo;
    logic [YEAR_W-1:0] yr;
    calendar_t         c;
    rest = secs;
    yr   = base;
    mo   = 0;
    while (rest >= days_in_year(yr) * SECS_PER_DAY) begin
      rest -= days_in_year(yr) * SECS_PER_DAY;
      yr = yr + 12'd1;
    end
    // December absorbs whatever is left
    while (mo < 11 && rest >= month_length(mo, yr) * SECS_PER_DAY) begin
      rest -= month_length(mo, yr) * SECS_PER_DAY;
      mo++;
    end
    c.year   = yr;
    c.month  = 4'(mo + 1);
    c.day    = 5'(1 + rest / SECS_PER_DAY);
    rest     = rest % SECS_PER_DAY;
    c.hour   = 5'(rest / 3600);
    c.minute = 6'((rest % 3600) / 60);
    c.second = 6'(rest % 60);
    return c;
  endfunction

  // seconds count of a real calendar instant, often on a day boundary
  function automatic logic [SEC_W-1:0] calendar_instant(input logic [YEAR_W-1:0] base);
    logic [63:0]       acc;
    logic [YEAR_W-1:0] yr;
    int unsigned       nyears;
    int unsigned       mo;
    int unsigned       sod;
    acc    = 0;
    yr     = base;
    nyears = $urandom_range(0, 136);
    for (int unsigned i = 0; i < nyears; i++) begin
      acc += days_in_year(yr) * SECS_PER_DAY;
      yr = yr + 12'd1;
    end
    mo = $urandom_range(0, 11);
    for (int unsigned i = 0; i < mo; i++) acc += month_length(i, yr) * SECS_PER_DAY;
    acc += $urandom_range(0, month_length(mo, yr) - 1) * SECS_PER_DAY;
    case ($urandom_range(0, 2))
      0:       sod = 0;
      1:       sod = SECS_PER_DAY - 1;
      default: sod = $urandom_range(0, SECS_PER_DAY - 1);
    endcase
    acc += sod;
    return (acc > 64'hFFFF_FFFF) ? $urandom() : acc[31:0];
  endfunction

  function automatic logic [SEC_W-1:0] pick_count(input logic [YEAR_W-1:0] base);
    int unsigned r;
    logic [SEC_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40)      v = $urandom();
    else if (r < 80) v = calendar_instant(base);
    else if (r < 92) v = $urandom_range(0, 3 * SECS_PER_DAY);
    else             v = 32'hFFFF_FFFF - $urandom_range(0, 100_000_000);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // ---- driver: presents queued counts, predicts at acceptance ----
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      model_base  = BASE_YEAR_RST;
    end else begin
      if (cfg_we) model_base = cfg_wdata;
      if (start && !busy) begin
        expected_dates.push_back(to_calendar(in_seconds_count, model_base));
        sent_count++;
      end
      if (!start || !busy) begin
        if (pending_counts.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          start            <= 1'b1;
          in_seconds_count <= pending_counts.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                                  out_year, out_month, out_day,
                                  out_hour, out_minute, out_second));
      end else begin
        want = expected_dates.pop_front();
        checked_count++;
        if (want.year < model_base) wrapped_count++;
        if (out_year !== want.year)
          report_mismatch($sformatf("year %0d, want %0d", out_year, want.year));
        if (out_month !== want.month)
          report_mismatch($sformatf("month %0d, want %0d", out_month, want.month));
        if (out_day !== want.day)
          report_mismatch($sformatf("day %0d, want %0d", out_day, want.day));
        if (out_hour !== want.hour)
          report_mismatch($sformatf("hour %0d, want %0d", out_hour, want.hour));
        if (out_minute !== want.minute)
          report_mismatch($sformatf("minute %0d, want %0d", out_minute, want.minute));
        if (out_second !== want.second)
          report_mismatch($sformatf("second %0d, want %0d", out_second, want.second));
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_counts.size() != 0 || expected_dates.size() != 0 || start || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [YEAR_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // ---- sequence ----
  initial begin
    logic [YEAR_W-1:0] phase_bases[PHASE_COUNT];
    phase_bases[0] = 12'd1900;
    phase_bases[1] = 12'd2100;
    phase_bases[2] = YEAR_MAX;    // counter wraps through year 0
    phase_bases[3] = 12'd0;
    phase_bases[4] = 12'd2000;
    phase_bases[5] = 12'd1970;
    phase_bases[6] = 12'($urandom_range(1900, 2100));
    phase_bases[7] = 12'($urandom_range(0, 4095));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset base 1970: time-of-day, month, year and leap edges
    pending_counts = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                       32'd86399, 32'd86400, 32'd2678399, 32'd2678400,
                       32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600,
                       32'd68256000, 32'd951782400, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
    wait_drained();

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      write_base(phase_bases[p]);
      steady = (p == 4);
      if (phase_bases[p] == YEAR_MAX) begin
        // year 0 start, year 0 leap day
        pending_counts.push_back(32'(365 * SECS_PER_DAY));
        pending_counts.push_back(32'(424 * SECS_PER_DAY));
        pending_counts.push_back(32'hFFFF_FFFF);
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++)
        pending_counts.push_back(pick_count(phase_bases[p]));
      wait_drained();
    end
    steady = 1'b0;
    repeat (20) @(negedge clk);

    $display("Converted %0d counts over %0d base-year settings, %0d results checked",
             sent_count, PHASE_COUNT + 1, checked_count);
    $display("%0d results landed past a year-counter wrap", wrapped_count);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout: %0d conversions still outstanding", expected_dates.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_sub.sv
rtl/esc_seq.sv
rtl/epoch_seconds_to_calendar.sv
sim/epoch_seconds_to_calendar_test.sv
